// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the PID controller RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_ON_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/core/pidda_pkg.sv =====
// ---------------------------------------------------------------------------
// pidda_pkg
// Shared types, widths and register indexes of the PID controller.
// ---------------------------------------------------------------------------
package pidda_pkg;

    localparam int ERR_W   = 17;   // setpoint - feedback, signed Q9.8
    localparam int ACC_W   = 32;   // integral accumulator
    localparam int PROD_W  = 48;   // 16 x 32 signed product
    localparam int SUM_W   = 41;   // sum of the three shifted products
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CIDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN_I         = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_GAIN_D         = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_DEADBAND       = 3'd5;

    localparam logic [14:0] OUTPUT_LIMIT_RST   = 15'h7FFF;
    localparam logic [30:0] INTEGRAL_LIMIT_RST = 31'h7FFF_FFFF;
    localparam logic [15:0] DEADBAND_RST       = 16'd51;   // about 0.2 in Q8.8

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic        [14:0] output_limit;
        logic        [30:0] integral_limit;
        logic        [15:0] deadband;
    } t_cfg;

endpackage

// ===== rtl/core/pidda_front.sv =====
// ---------------------------------------------------------------------------
// pidda_front
// Input side: forms the error of each beat, applies the deadband and pushes
// the result into the queue.
// ---------------------------------------------------------------------------
module pidda_front (
    input  logic                                i_valid,
    input  logic signed [15:0]                  i_setpoint,
    input  logic signed [15:0]                  i_feedback,
    input  logic        [15:0]                  i_deadband,
    input  logic                                i_full,
    output logic                                o_stall,
    output logic                                o_push,
    output logic signed [pidda_pkg::ERR_W-1:0]  o_error
);

    logic signed [pidda_pkg::ERR_W-1:0] w_err;
    logic        [pidda_pkg::ERR_W-1:0] w_mag;

    assign w_err = {i_setpoint[15], i_setpoint} - {i_feedback[15], i_feedback};
    // |e| never exceeds 65535, so 17 unsigned bits hold it
    assign w_mag = w_err[pidda_pkg::ERR_W-1] ? -w_err : w_err;

    always_comb begin
        if (w_mag < {1'b0, i_deadband}) begin
            o_error = '0;
        end else begin
            o_error = w_err;
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== rtl/core/pidda_queue.sv =====
// ---------------------------------------------------------------------------
// pidda_queue
// Small FIFO of deadbanded errors between the front and back ends.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pidda_queue #(
    parameter int DEPTH = pidda_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic signed [pidda_pkg::ERR_W-1:0]  i_data,
    input  logic                                i_pop,
    output logic signed [pidda_pkg::ERR_W-1:0]  o_data,
    output logic                                o_empty,
    output logic                                o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [pidda_pkg::ERR_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_q_overfill, i_clk, i_rst_n, r_count > CNT_W'(DEPTH), "queue count past depth")
    `ASSERT_NEVER(a_q_underrun, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `ASSERT_ON_CLK(a_q_grow, i_clk, i_rst_n, i_push && !i_pop |=> r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

// ===== rtl/core/pidda_back.sv =====
// ---------------------------------------------------------------------------
// pidda_back
// Execution side: integral update, three products on one shared multiplier,
// sum, output clamp and the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pidda_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pidda_pkg::t_cfg                     i_cfg,
    input  logic                                i_empty,
    input  logic signed [pidda_pkg::ERR_W-1:0]  i_error,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [15:0]                  o_drive
);

    localparam int ERR_W  = pidda_pkg::ERR_W;
    localparam int ACC_W  = pidda_pkg::ACC_W;
    localparam int PROD_W = pidda_pkg::PROD_W;
    localparam int SUM_W  = pidda_pkg::SUM_W;
    localparam int SHR_W  = PROD_W - 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MI,
        S_MD,
        S_FIN
    } t_state;

    t_state r_state;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [ERR_W:0]    r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_out_valid;
    logic signed [15:0]       r_drive;

    logic signed [ACC_W:0]    w_acc_sum;
    logic signed [ACC_W:0]    w_ilim;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [15:0]       w_mul_a;
    logic signed [ACC_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SUM_W-1:0]  w_prod_shr;
    logic signed [SUM_W-1:0]  w_fin;
    logic signed [SUM_W-1:0]  w_olim;
    logic signed [15:0]       n_drive;
    logic                     w_load;

    // integral update with symmetric clamp
    assign w_acc_sum = {r_acc[ACC_W-1], r_acc}
                     + {{(ACC_W + 1 - ERR_W){i_error[ERR_W-1]}}, i_error};
    assign w_ilim    = {2'b00, i_cfg.integral_limit};

    always_comb begin
        if (w_acc_sum > w_ilim) begin
            n_acc = w_ilim[ACC_W-1:0];
        end else if (w_acc_sum < -w_ilim) begin
            n_acc = ACC_W'(-w_ilim);
        end else begin
            n_acc = w_acc_sum[ACC_W-1:0];
        end
    end

    // shared multiplier: P on pop, then I in S_MI and D in S_MD
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                w_mul_a = i_cfg.gain_p;
                w_mul_b = {{(ACC_W - ERR_W){i_error[ERR_W-1]}}, i_error};
            end
            S_MI: begin
                w_mul_a = i_cfg.gain_i;
                w_mul_b = r_acc;
            end
            default: begin
                w_mul_a = i_cfg.gain_d;
                w_mul_b = {{(ACC_W - ERR_W - 1){r_diff[ERR_W]}}, r_diff};
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // floor shift by 8 of the registered product
    assign w_prod_shr = {{(SUM_W - SHR_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:8]};
    assign w_fin      = r_sum + w_prod_shr;
    assign w_olim     = {{(SUM_W - 15){1'b0}}, i_cfg.output_limit};

    always_comb begin
        if (w_fin > w_olim) begin
            n_drive = w_olim[15:0];
        end else if (w_fin < -w_olim) begin
            n_drive = 16'(-w_olim);
        end else begin
            n_drive = w_fin[15:0];
        end
    end

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign w_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_acc   <= n_acc;
                        r_prev  <= i_error;
                        r_diff  <= {i_error[ERR_W-1], i_error} - {r_prev[ERR_W-1], r_prev};
                        r_prod  <= w_prod;
                        r_state <= S_MI;
                    end
                end
                S_MI: begin
                    r_sum   <= w_prod_shr;
                    r_prod  <= w_prod;
                    r_state <= S_MD;
                end
                S_MD: begin
                    r_sum   <= w_fin;
                    r_prod  <= w_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_drive     <= n_drive;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    `ASSERT_ON_CLK(a_bk_pop_start, i_clk, i_rst_n, o_pop |=> r_state == S_MI, "pop did not start products")
    `ASSERT_ON_CLK(a_bk_load_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FIN), "output loaded outside final step")
    `ASSERT_ON_CLK(a_bk_fin_hold, i_clk, i_rst_n, (r_state == S_FIN) && !w_load |=> r_state == S_FIN, "result dropped while output busy")

endmodule

// ===== rtl/core/pid_deadband_antiwindup.sv =====
// ---------------------------------------------------------------------------
// pid_deadband_antiwindup
// Positional PID controller step, signed Q8.8, with error deadband and
// integral anti-windup.
// ---------------------------------------------------------------------------
// Each input beat carries a setpoint and a feedback value. The error
// e = setpoint - feedback is zeroed when |e| is below the deadband, added to
// the integral (clamped to +/- integral_limit), and the output
// (Kp*e)>>>8 + (Ki*integral)>>>8 + (Kd*(e - last e))>>>8 is clamped to
// +/- output_limit and sent out as one drive beat per input beat, in order.
// The front end takes an input beat every cycle as long as the error queue
// (QUEUE_DEPTH entries) has room; the back end works on one beat at a time,
// its single 16x32 multiplier stepping through the P, I and D products in
// turn before the result goes to the output register, which lets the back
// end keep working while a finished drive beat waits on i_out_stall.
// Configuration registers (index: 0 gain_p, 1 gain_i, 2 gain_d,
// 3 output_limit, 4 integral_limit, 5 deadband) are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// Unused upper data bits and writes to other indexes are ignored.
// ---------------------------------------------------------------------------
module pid_deadband_antiwindup #(
    parameter int QUEUE_DEPTH = pidda_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [15:0]                i_setpoint,
    input  logic signed [15:0]                i_feedback,
    // output beats
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [15:0]                o_drive,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pidda_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [pidda_pkg::CDATA_W-1:0]     i_cfg_data
);

    pidda_pkg::t_cfg r_cfg;

    logic                                 w_push;
    logic signed [pidda_pkg::ERR_W-1:0]   w_push_err;
    logic                                 w_pop;
    logic signed [pidda_pkg::ERR_W-1:0]   w_head_err;
    logic                                 w_empty;
    logic                                 w_full;

    // register file: always ready, one write per beat
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.output_limit   <= pidda_pkg::OUTPUT_LIMIT_RST;
            r_cfg.integral_limit <= pidda_pkg::INTEGRAL_LIMIT_RST;
            r_cfg.deadband       <= pidda_pkg::DEADBAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pidda_pkg::CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_data[15:0];
                pidda_pkg::CFG_GAIN_I:         r_cfg.gain_i         <= i_cfg_data[15:0];
                pidda_pkg::CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_data[15:0];
                pidda_pkg::CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_data[14:0];
                pidda_pkg::CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[30:0];
                pidda_pkg::CFG_DEADBAND:       r_cfg.deadband       <= i_cfg_data[15:0];
                default: begin
                    // unknown index: no register changes
                end
            endcase
        end
    end

    // front end: error and deadband, straight into the queue
    pidda_front u_front (
        .i_valid    (i_in_valid),
        .i_setpoint (i_setpoint),
        .i_feedback (i_feedback),
        .i_deadband (r_cfg.deadband),
        .i_full     (w_full),
        .o_stall    (o_in_stall),
        .o_push     (w_push),
        .o_error    (w_push_err)
    );

    pidda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_err),
        .i_pop   (w_pop),
        .o_data  (w_head_err),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // back end: integral, products, clamp, output register
    pidda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (w_empty),
        .i_error     (w_head_err),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive)
    );

endmodule
